// ===== rtl/core/aja_pkg.sv =====
// Shared constants and the arctangent table of the arm joint angle unit.
package aja_pkg;

  localparam int COORD_BITS_DEF      = 14;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 32;
  localparam int MAG_BITS     = 31;
  localparam int ANG_BITS     = 31;
  localparam int NORM_BITS    = 30;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'h3243F6A8;
      1:  v = 30'h1DAC6705;
      2:  v = 30'h0FADBAFC;
      3:  v = 30'h07F56EA6;
      4:  v = 30'h03FEAB76;
      5:  v = 30'h01FFD55B;
      6:  v = 30'h00FFFAAA;
      7:  v = 30'h007FFF55;
      8:  v = 30'h003FFFEA;
      9:  v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      24: v = 30'h0000003F;
      25: v = 30'h0000001F;
      26: v = 30'h0000000F;
      27: v = 30'h00000008;
      28: v = 30'h00000004;
      29: v = 30'h00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/aja_pose_if.sv =====
// Input channel carrying one arm pose word.
interface aja_pose_if #(parameter int COORD_BITS = aja_pkg::COORD_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          arm_side;
  logic signed [COORD_BITS-1:0]  shoulder_x;
  logic signed [COORD_BITS-1:0]  shoulder_y;
  logic signed [COORD_BITS-1:0]  shoulder_z;
  logic signed [COORD_BITS-1:0]  elbow_x;
  logic signed [COORD_BITS-1:0]  elbow_y;
  logic signed [COORD_BITS-1:0]  elbow_z;
  logic signed [COORD_BITS-1:0]  wrist_x;
  logic signed [COORD_BITS-1:0]  wrist_y;
  logic signed [COORD_BITS-1:0]  wrist_z;

  modport source(output valid, arm_side, shoulder_x, shoulder_y, shoulder_z, elbow_x,
                 elbow_y, elbow_z, wrist_x, wrist_y, wrist_z, input ready);
  modport sink(input valid, arm_side, shoulder_x, shoulder_y, shoulder_z, elbow_x,
               elbow_y, elbow_z, wrist_x, wrist_y, wrist_z, output ready);
endinterface

// ===== rtl/core/aja_angle_if.sv =====
// Output channel carrying one pair of servo angles.
interface aja_angle_if #(parameter int ANGLE_FRAC_BITS = aja_pkg::ANGLE_FRAC_BITS_DEF);
  logic                               valid;
  logic                               ready;
  logic                               side_tag;
  logic signed [ANGLE_FRAC_BITS+2:0]  shoulder_angle;
  logic signed [ANGLE_FRAC_BITS+2:0]  elbow_angle;
  logic                               degenerate;

  modport source(output valid, side_tag, shoulder_angle, elbow_angle, degenerate,
                 input ready);
  modport sink(input valid, side_tag, shoulder_angle, elbow_angle, degenerate,
               output ready);
endinterface

// ===== rtl/core/aja_atan.sv =====
// Pipelined vectoring CORDIC arctangent of ay/ax as unsigned Q1.30, one stage per iteration.
module aja_atan #(
  parameter int TAG_BITS = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [aja_pkg::MAG_BITS-1:0]  ax,
  input  logic [aja_pkg::MAG_BITS-1:0]  ay,
  input  logic [TAG_BITS-1:0]           tag_in,
  output logic                          out_vld,
  output logic [aja_pkg::ANG_BITS-1:0]  angle,
  output logic [TAG_BITS-1:0]           tag_out
);
  import aja_pkg::*;

  localparam int CW = 34;
  localparam int PW = $clog2(MAG_BITS);

  logic                 a_vld;
  logic [MAG_BITS-1:0]  a_x;
  logic [MAG_BITS-1:0]  a_y;
  logic [PW-1:0]        a_p;
  logic                 a_zero;
  logic [TAG_BITS-1:0]  a_tag;
  logic [PW-1:0]        p_next;
  logic [MAG_BITS-1:0]  orv;

  logic                 vld [0:CORDIC_STEPS];
  logic signed [CW-1:0] xq  [0:CORDIC_STEPS];
  logic signed [CW-1:0] yq  [0:CORDIC_STEPS];
  logic signed [CW-1:0] zq  [0:CORDIC_STEPS];
  logic                 zro [0:CORDIC_STEPS];
  logic [TAG_BITS-1:0]  tg  [0:CORDIC_STEPS];
  logic [PW-1:0]        sl;

  logic                 c_vld;
  logic [ANG_BITS-1:0]  c_ang;
  logic [TAG_BITS-1:0]  c_tag;
  logic [ANG_BITS-1:0]  ang_next;
  logic signed [CW-1:0] zf;

  always_comb begin
    orv = ax | ay;
    p_next = '0;
    for (int j = 0; j < MAG_BITS; j++) begin
      if (orv[j]) p_next = PW'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= ax;
      a_y    <= ay;
      a_p    <= p_next;
      a_zero <= (orv == '0);
      a_tag  <= tag_in;
    end
  end

  assign sl = PW'(NORM_BITS - 1) - a_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_p == PW'(NORM_BITS)) begin
        xq[0] <= CW'(a_x >> 1);
        yq[0] <= CW'(a_y >> 1);
      end else begin
        xq[0] <= CW'(a_x) << sl;
        yq[0] <= CW'(a_y) << sl;
      end
      zq[0]  <= '0;
      zro[0] <= a_zero;
      tg[0]  <= a_tag;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] tv;

    assign xs = xq[i] >>> i;
    assign ys = yq[i] >>> i;
    assign tv = CW'(atan_q30(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yq[i][CW-1]) begin
          xq[i+1] <= xq[i] - ys;
          yq[i+1] <= yq[i] + xs;
          zq[i+1] <= zq[i] - tv;
        end else begin
          xq[i+1] <= xq[i] + ys;
          yq[i+1] <= yq[i] - xs;
          zq[i+1] <= zq[i] + tv;
        end
        zro[i+1] <= zro[i];
        tg[i+1]  <= tg[i];
      end
    end
  end

  assign zf = zq[CORDIC_STEPS];

  always_comb begin
    if (zro[CORDIC_STEPS] || zf[CW-1]) begin
      ang_next = '0;
    end else if (zf[CW-2:0] > (CW-1)'(PI_HALF_Q30)) begin
      ang_next = ANG_BITS'(PI_HALF_Q30);
    end else begin
      ang_next = zf[ANG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ang <= ang_next;
      c_tag <= tg[CORDIC_STEPS];
    end
  end

  assign out_vld = c_vld;
  assign angle   = c_ang;
  assign tag_out = c_tag;
endmodule

// ===== rtl/core/arm_joint_angles_unit.sv =====
// Arm joint angle unit: shoulder and signed elbow servo angles from three joint positions.
//
// The pose channel takes one word per cycle: side tag and the shoulder, elbow and wrist
// positions in signed millimeters. The angle channel gives one word per pose, in order:
// the echoed side tag, the shoulder and elbow angles in radians (signed, ANGLE_FRAC_BITS
// fraction bits) and a flag that is set when the shoulder or elbow angle is undefined.
// The datapath is a single pipeline of 74 register stages: vector differences, products,
// cross and dot sums, magnitude normalization, squares, a 32 stage square root, two
// parallel 33 stage CORDIC arctangent lanes, rounding and sign selection. A new pose
// is accepted every cycle while the output is taken. The last stage is the output
// register. When the receiver holds ready low with a result waiting, every stage
// holds its contents and pose ready drops, so no word is lost or repeated; the pipeline
// resumes when the word is taken. Reset clears all valid bits; the pipeline is empty
// and ready is high in the first cycle after reset.
module arm_joint_angles_unit #(
  parameter int COORD_BITS      = aja_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = aja_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  aja_pose_if.sink    pose,
  aja_angle_if.source angles
);
  import aja_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int QW   = 2 * DW;
  localparam int SW   = QW + 2;
  localparam int HW   = $clog2(SW);
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int RW   = F + 3;
  localparam int ETAG = 7;
  localparam logic [32:0] RND = 33'(1) << (29 - F);
  localparam logic signed [RW-1:0] PI_LIM = RW'((33'(PI_Q30) + RND) >> (30 - F));

  typedef struct packed {
    logic                  side;
    logic                  sdeg;
    logic                  s_zero;
    logic                  s_neg;
    logic                  edeg;
    logic                  d_neg;
    logic                  cz_pos;
    logic                  cz_neg;
    logic [NORM_BITS-1:0]  md;
    logic [DW-1:0]         s_ax;
    logic [DW-1:0]         s_ay;
  } band_t;

  logic en;
  logic o_vld;

  // Stage 1: upper and lower arm vectors.
  logic                 v1;
  logic                 side1;
  logic signed [C-1:0]  sy1;
  logic signed [DW-1:0] ux1, uy1, uz1, vx1, vy1, vz1;

  // Stage 2: products.
  logic                 v2;
  band_t                b2;
  logic signed [QW-1:0] pdx, pdy, pdz, pa1, pa2, pb1, pb2, pc1, pc2;
  logic                 uzero, vzero;

  // Stage 3: dot and cross sums.
  logic                 v3;
  band_t                b3;
  logic signed [SW-1:0] d3, cx3, cy3, cz3;

  // Stage 4: magnitudes.
  logic                 v4;
  band_t                b4;
  band_t                b4_next;
  logic [SW-1:0]        md4, mx4, my4, mz4;

  // Stage 5: common right shift below 2^30.
  logic                 v5;
  band_t                b5;
  band_t                b5_next;
  logic [NORM_BITS-1:0] mx5, my5, mz5;
  logic [SW-1:0]        orv;
  logic [HW-1:0]        hb;
  logic [HW-1:0]        sh;

  // Stage 6: squares; stage 7: their sum.
  logic                 v6;
  band_t                b6;
  logic [59:0]          qx6, qy6, qz6;

  // Square root chain, index 0 is stage 7.
  logic                 rv [0:ROOT_STEPS];
  band_t                rb [0:ROOT_STEPS];
  logic [63:0]          nq [0:ROOT_STEPS];
  logic [63:0]          rq [0:ROOT_STEPS];

  // Arctangent lanes.
  logic                 e_vld, s_vld;
  logic [ANG_BITS-1:0]  e_ang, s_ang;
  logic [ETAG-1:0]      e_tag;
  logic                 s_tag;
  logic [MAG_BITS-1:0]  e_ax, e_ay, s_ax, s_ay;

  // Rounding stage.
  logic                 v8;
  logic [ETAG-1:0]      t8;
  logic                 n8;
  logic [RW-1:0]        er8, sr8;
  logic [31:0]          ea;
  logic [32:0]          esum, ssum;

  // Output register.
  logic                 o_side;
  logic signed [RW-1:0] o_sh;
  logic signed [RW-1:0] o_el;
  logic                 o_deg;

  assign en = !o_vld || angles.ready;
  assign pose.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      rv[0] <= 1'b0;
    end else if (en) begin
      v1 <= pose.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      rv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= pose.arm_side;
      sy1   <= pose.shoulder_y;
      ux1   <= DW'(pose.elbow_x) - DW'(pose.shoulder_x);
      uy1   <= DW'(pose.elbow_y) - DW'(pose.shoulder_y);
      uz1   <= DW'(pose.elbow_z) - DW'(pose.shoulder_z);
      vx1   <= DW'(pose.wrist_x) - DW'(pose.elbow_x);
      vy1   <= DW'(pose.wrist_y) - DW'(pose.elbow_y);
      vz1   <= DW'(pose.wrist_z) - DW'(pose.elbow_z);
    end
  end

  assign uzero = (ux1 == '0) && (uy1 == '0) && (uz1 == '0);
  assign vzero = (vx1 == '0) && (vy1 == '0) && (vz1 == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      pdx <= ux1 * vx1;
      pdy <= uy1 * vy1;
      pdz <= uz1 * vz1;
      pa1 <= vy1 * uz1;
      pa2 <= vz1 * uy1;
      pb1 <= vz1 * ux1;
      pb2 <= vx1 * uz1;
      pc1 <= vx1 * uy1;
      pc2 <= vy1 * ux1;
      b2.side   <= side1;
      b2.sdeg   <= (sy1 == '0) || ((ux1 == '0) && (uy1 == '0));
      b2.s_zero <= (uy1 == '0);
      b2.s_neg  <= (!sy1[C-1]) == (!uy1[DW-1]);
      b2.edeg   <= uzero || vzero;
      b2.d_neg  <= 1'b0;
      b2.cz_pos <= 1'b0;
      b2.cz_neg <= 1'b0;
      b2.md     <= '0;
      b2.s_ax   <= ux1[DW-1] ? DW'(-ux1) : DW'(ux1);
      b2.s_ay   <= uy1[DW-1] ? DW'(-uy1) : DW'(uy1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3  <= b2;
      d3  <= SW'(pdx) + SW'(pdy) + SW'(pdz);
      cx3 <= SW'(pa1) - SW'(pa2);
      cy3 <= SW'(pb1) - SW'(pb2);
      cz3 <= SW'(pc1) - SW'(pc2);
    end
  end

  always_comb begin
    b4_next        = b3;
    b4_next.d_neg  = d3[SW-1];
    b4_next.cz_neg = cz3[SW-1];
    b4_next.cz_pos = !cz3[SW-1] && (cz3 != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4  <= b4_next;
      md4 <= d3[SW-1] ? SW'(-d3) : SW'(d3);
      mx4 <= cx3[SW-1] ? SW'(-cx3) : SW'(cx3);
      my4 <= cy3[SW-1] ? SW'(-cy3) : SW'(cy3);
      mz4 <= cz3[SW-1] ? SW'(-cz3) : SW'(cz3);
    end
  end

  always_comb begin
    orv = md4 | mx4 | my4 | mz4;
    hb = '0;
    for (int j = 0; j < SW; j++) begin
      if (orv[j]) hb = HW'(j);
    end
    if (int'(hb) >= NORM_BITS) begin
      sh = HW'(int'(hb) - (NORM_BITS - 1));
    end else begin
      sh = '0;
    end
  end

  always_comb begin
    b5_next    = b4;
    b5_next.md = NORM_BITS'(md4 >> sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5    <= b5_next;
      mx5   <= NORM_BITS'(mx4 >> sh);
      my5   <= NORM_BITS'(my4 >> sh);
      mz5   <= NORM_BITS'(mz4 >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b6  <= b5;
      qx6 <= 60'(mx5) * 60'(mx5);
      qy6 <= 60'(my5) * 60'(my5);
      qz6 <= 60'(mz5) * 60'(mz5);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rb[0] <= b6;
      nq[0] <= 64'(qx6) + 64'(qy6) + 64'(qz6);
      rq[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = rq[k] + BITV;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (en) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rb[k+1] <= rb[k];
        if (nq[k] >= trial) begin
          nq[k+1] <= nq[k] - trial;
          rq[k+1] <= (rq[k] >> 1) + BITV;
        end else begin
          nq[k+1] <= nq[k];
          rq[k+1] <= rq[k] >> 1;
        end
      end
    end
  end

  assign e_ax = MAG_BITS'(rb[ROOT_STEPS].md);
  assign e_ay = rq[ROOT_STEPS][MAG_BITS-1:0];
  assign s_ax = MAG_BITS'(rb[ROOT_STEPS].s_ax);
  assign s_ay = MAG_BITS'(rb[ROOT_STEPS].s_ay);

  aja_atan #(.TAG_BITS(ETAG)) u_elbow_atan (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (rv[ROOT_STEPS]),
    .ax      (e_ax),
    .ay      (e_ay),
    .tag_in  ({rb[ROOT_STEPS].side, rb[ROOT_STEPS].sdeg, rb[ROOT_STEPS].s_zero,
               rb[ROOT_STEPS].edeg, rb[ROOT_STEPS].d_neg, rb[ROOT_STEPS].cz_pos,
               rb[ROOT_STEPS].cz_neg}),
    .out_vld (e_vld),
    .angle   (e_ang),
    .tag_out (e_tag)
  );

  aja_atan #(.TAG_BITS(1)) u_shoulder_atan (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (rv[ROOT_STEPS]),
    .ax      (s_ax),
    .ay      (s_ay),
    .tag_in  (rb[ROOT_STEPS].s_neg),
    .out_vld (s_vld),
    .angle   (s_ang),
    .tag_out (s_tag)
  );

  // Elbow tag order: side, sdeg, s_zero, edeg, d_neg, cz_pos, cz_neg.
  assign ea   = e_tag[2] ? (PI_Q30 - 32'(e_ang)) : 32'(e_ang);
  assign esum = 33'(ea) + RND;
  assign ssum = 33'(s_ang) + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t8  <= e_tag;
      n8  <= s_tag;
      er8 <= RW'(esum >> (30 - F));
      sr8 <= RW'(ssum >> (30 - F));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_side <= t8[6];
      o_deg  <= t8[5] || t8[3];
      if (t8[5] || t8[4]) begin
        o_sh <= '0;
      end else if (n8) begin
        o_sh <= -$signed(sr8);
      end else begin
        o_sh <= $signed(sr8);
      end
      if (t8[3]) begin
        o_el <= '0;
      end else if (t8[1]) begin
        o_el <= $signed(er8);
      end else if (t8[0]) begin
        o_el <= -$signed(er8);
      end else begin
        o_el <= '0;
      end
    end
  end

  assign angles.valid          = o_vld;
  assign angles.side_tag       = o_side;
  assign angles.shoulder_angle = o_sh;
  assign angles.elbow_angle    = o_el;
  assign angles.degenerate     = o_deg;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) e_vld == s_vld)
    else $error("Arctangent lanes out of step.");
  a_reset_empty: assert property (@(posedge clk) rst |=> !angles.valid)
    else $error("Output valid after reset.");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
      (angles.valid && !angles.ready) |-> !pose.ready)
    else $error("Pose taken while the output is stalled.");
  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
      angles.valid |-> (angles.elbow_angle <= PI_LIM && angles.elbow_angle >= -PI_LIM))
    else $error("Elbow angle beyond pi.");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
      (angles.valid && angles.shoulder_angle != '0 && angles.elbow_angle != '0)
      |-> !angles.degenerate)
    else $error("Degenerate flag mismatch.");
`endif
endmodule

// ===== tb/arm_joint_angles_checker.sv =====
// Angle checker: predicts each pose's servo angles and compares them with the output words.
`timescale 1ns / 100ps

module arm_joint_angles_checker (
  input  logic clk,
  input  logic rst,
  aja_pose_if  pose,
  aja_angle_if angles,
  output int   fail_count,
  output int   pending,
  output int   degen_seen
);

  localparam int FRAC = aja_pkg::ANGLE_FRAC_BITS_DEF;
  localparam longint PI_FIX   = longint'(aja_pkg::PI_Q30);
  localparam longint HALF_FIX = longint'(aja_pkg::PI_HALF_Q30);

  typedef struct {
    logic               side;
    logic signed [14:0] shoulder;
    logic signed [14:0] elbow;
    logic               degen;
  } angle_word_t;

  angle_word_t angle_q[$];

  function automatic longint cordic_atan(longint unsigned ax, longint unsigned ay);
    longint unsigned mx;
    longint x, y, z, xs, ys;
    mx = (ax > ay) ? ax : ay;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      ax = ax << 1; ay = ay << 1; mx = mx << 1;
    end
    x = longint'(ax);
    y = longint'(ay);
    z = 0;
    for (int i = 0; i < aja_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - longint'(aja_pkg::atan_q30(i));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(aja_pkg::atan_q30(i));
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_FIX) z = HALF_FIX;
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint to_q12(longint a);
    return (a + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic angle_word_t predict_angles(logic side, longint sx, longint sy,
      longint sz, longint ex, longint ey, longint ez, longint wx, longint wy, longint wz);
    angle_word_t w;
    longint ux, uy, uz, vx, vy, vz, d, cx, cy, cz, a, r, sh, el;
    longint unsigned mcx, mcy, mcz, md, top, m;
    ux = ex - sx; uy = ey - sy; uz = ez - sz;
    vx = wx - ex; vy = wy - ey; vz = wz - ez;
    sh = 0;
    el = 0;
    w.degen = 1'b0;
    if (sy == 0 || (ux == 0 && uy == 0)) begin
      w.degen = 1'b1;
    end else if (uy != 0) begin
      r = to_q12(cordic_atan(magn(ux), magn(uy)));
      sh = ((sy > 0) == (uy > 0)) ? -r : r;
    end
    if ((ux == 0 && uy == 0 && uz == 0) || (vx == 0 && vy == 0 && vz == 0)) begin
      w.degen = 1'b1;
    end else begin
      d  = ux * vx + uy * vy + uz * vz;
      cx = vy * uz - vz * uy;
      cy = vz * ux - vx * uz;
      cz = vx * uy - vy * ux;
      mcx = magn(cx); mcy = magn(cy); mcz = magn(cz); md = magn(d);
      top = mcx;
      if (mcy > top) top = mcy;
      if (mcz > top) top = mcz;
      if (md > top) top = md;
      while (top >= (64'd1 << 30)) begin
        mcx = mcx >> 1; mcy = mcy >> 1; mcz = mcz >> 1; md = md >> 1; top = top >> 1;
      end
      m = int_sqrt(mcx * mcx + mcy * mcy + mcz * mcz);
      a = cordic_atan(md, m);
      if (d < 0) a = PI_FIX - a;
      r = to_q12(a);
      if (cz > 0) el = r;
      else if (cz < 0) el = -r;
    end
    w.side     = side;
    w.shoulder = sh[14:0];
    w.elbow    = el[14:0];
    return w;
  endfunction

  initial begin
    fail_count = 0;
    degen_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    angle_word_t exp_w;
    if (!rst && pose.valid && pose.ready) begin
      angle_q.push_back(predict_angles(pose.arm_side, pose.shoulder_x, pose.shoulder_y,
          pose.shoulder_z, pose.elbow_x, pose.elbow_y, pose.elbow_z, pose.wrist_x,
          pose.wrist_y, pose.wrist_z));
    end
    if (!rst && angles.valid && angles.ready) begin
      if (angle_q.size() == 0) begin
        $error("angle word with no pose waiting");
        fail_count++;
      end else begin
        exp_w = angle_q.pop_front();
        if (exp_w.degen) degen_seen++;
        if (angles.side_tag !== exp_w.side) begin
          $error("side_tag: expected %0d, got %0d", exp_w.side, angles.side_tag);
          fail_count++;
        end
        if (angles.shoulder_angle !== exp_w.shoulder) begin
          $error("shoulder_angle: expected %0d, got %0d", exp_w.shoulder,
                 angles.shoulder_angle);
          fail_count++;
        end
        if (angles.elbow_angle !== exp_w.elbow) begin
          $error("elbow_angle: expected %0d, got %0d", exp_w.elbow, angles.elbow_angle);
          fail_count++;
        end
        if (angles.degenerate !== exp_w.degen) begin
          $error("degenerate: expected %0d, got %0d", exp_w.degen, angles.degenerate);
          fail_count++;
        end
      end
    end
    pending = angle_q.size();
  end

endmodule

// ===== tb/arm_joint_angles_unit_tb.sv =====
// Top testbench of the arm joint angle unit: clock, reset, pose stimulus and verdict.
`timescale 1ns / 100ps

module arm_joint_angles_unit_tb;

  localparam int LATENCY = 74;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_POSES = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, degen_seen;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   sent = 0;
  logic hold_req = 1'b0;

  aja_pose_if  pose_ch ();
  aja_angle_if angle_ch ();

  arm_joint_angles_unit dut (
    .clk(clk), .rst(rst), .pose(pose_ch), .angles(angle_ch)
  );

  arm_joint_angles_checker checker_i (
    .clk(clk), .rst(rst), .pose(pose_ch), .angles(angle_ch),
    .fail_count(fail_count), .pending(pending), .degen_seen(degen_seen)
  );

  always #5 clk = ~clk;

  initial begin
    pose_ch.valid = 1'b0;
    pose_ch.arm_side = 1'b0;
    {pose_ch.shoulder_x, pose_ch.shoulder_y, pose_ch.shoulder_z} = '0;
    {pose_ch.elbow_x, pose_ch.elbow_y, pose_ch.elbow_z} = '0;
    {pose_ch.wrist_x, pose_ch.wrist_y, pose_ch.wrist_z} = '0;
    angle_ch.ready = 1'b0;
  end

  initial begin
    int mode, count;
    mode = 0;
    count = 0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        angle_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_req = 1'b0;
      end
      if (count == 0) begin
        mode = $urandom_range(0, 2);
        count = $urandom_range(20, 120);
      end
      count--;
      case (mode)
        0: begin
          angle_ch.ready <= 1'b1;
        end
        1: begin
          angle_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          angle_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((pose_ch.valid && pose_ch.ready) || (angle_ch.valid && angle_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_pose(logic side, logic signed [13:0] sx, sy, sz, ex, ey, ez,
                           wx, wy, wz);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      pose_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    pose_ch.arm_side = side;
    pose_ch.shoulder_x = sx; pose_ch.shoulder_y = sy; pose_ch.shoulder_z = sz;
    pose_ch.elbow_x = ex;    pose_ch.elbow_y = ey;    pose_ch.elbow_z = ez;
    pose_ch.wrist_x = wx;    pose_ch.wrist_y = wy;    pose_ch.wrist_z = wz;
    pose_ch.valid = 1'b1;
    @(posedge clk);
    while (!pose_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [13:0] any_coord();
    return 14'($urandom);
  endfunction

  function automatic logic signed [13:0] near(logic signed [13:0] base, int span);
    return base + 14'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_random_pose();
    logic signed [13:0] sx, sy, sz, ex, ey, ez, wx, wy, wz;
    int kind, k;
    logic side;
    side = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 11);
    sx = any_coord(); sy = any_coord(); sz = any_coord();
    if (kind < 4) begin
      ex = any_coord(); ey = any_coord(); ez = any_coord();
      wx = any_coord(); wy = any_coord(); wz = any_coord();
    end else begin
      sx = near(0, 3000); sy = near(0, 3000); sz = near(0, 3000);
      ex = near(sx, 600); ey = near(sy, 600); ez = near(sz, 600);
      wx = near(ex, 600); wy = near(ey, 600); wz = near(ez, 600);
      case (kind)
        5: sy = '0;
        6: begin
          ex = sx; ey = sy;
        end
        7: begin
          ex = sx; ey = sy; ez = sz;
        end
        8: begin
          wx = ex; wy = ey; wz = ez;
        end
        9: ey = sy;
        10: begin
          k = $urandom_range(1, 2);
          wx = 14'(ex + k * (ex - sx));
          wy = 14'(ey + k * (ey - sy));
        end
        11: begin
          sx = near(0, 4); sy = near(0, 4); sz = near(0, 4);
          ex = near(sx, 3); ey = near(sy, 3); ez = near(sz, 3);
          wx = near(ex, 3); wy = near(ey, 3); wz = near(ez, 3);
        end
        default: ;
      endcase
    end
    send_pose(side, sx, sy, sz, ex, ey, ez, wx, wy, wz);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pose(1'b0, -8192, -8192, -8192, 8191, 8191, 8191, -8192, -8192, -8192);
    send_pose(1'b1, 8191, 8191, 8191, -8192, -8192, -8192, 8191, 8191, 8191);
    send_pose(1'b1, -8192, 8191, -8192, 8191, -8192, 8191, 8191, 8191, -8192);
    send_pose(1'b0, 0, 0, 0, 100, 100, 0, 200, 0, 0);
    send_pose(1'b1, 10, 20, 30, 10, 20, 30, 50, 60, 70);
    send_pose(1'b0, 10, 20, 30, 10, 20, 90, 50, 60, 70);
    send_pose(1'b1, 10, 20, 30, 50, 60, 70, 50, 60, 70);
    send_pose(1'b0, 10, 20, 30, 80, 20, 30, 80, 90, 30);
    send_pose(1'b1, 0, 5, 0, 100, 5, 0, 200, 5, 0);
    send_pose(1'b0, 0, 5, 0, 100, 105, 0, 300, 305, 0);
    send_pose(1'b1, 0, 5, 0, 100, 105, 0, 0, 5, 0);
    send_pose(1'b0, 0, -5, 0, 0, 100, 0, 0, 100, 100);
    send_pose(1'b1, 0, -5, 0, 1, -4, 0, 1, -4, 1);
    send_pose(1'b0, 0, 1, 0, -1, 2, 0, -1, 2, -1);
    send_pose(1'b1, 0, 8191, 0, 8191, -8192, 0, -8192, -8192, 8191);
    send_pose(1'b0, 0, 7, 0, 0, 7, 0, 0, 7, 0);

    for (int n = 0; n < RANDOM_POSES; n++) begin
      if (n == 500) hold_req = 1'b1;
      if (n == 900) begin
        @(negedge clk);
        pose_ch.valid = 1'b0;
        wait (pending == 0);
      end
      send_random_pose();
    end
    @(negedge clk);
    pose_ch.valid = 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d poses (directed extremes and degenerate cases, then random).", sent);
    $display("Results included %0d degenerate words, a long output stall and a drain pause.",
             degen_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/aja_pkg.sv
rtl/core/aja_pose_if.sv
rtl/core/aja_angle_if.sv
rtl/core/aja_atan.sv
rtl/core/arm_joint_angles_unit.sv
tb/arm_joint_angles_checker.sv
tb/arm_joint_angles_unit_tb.sv
